// ===== sv/tie_pkg.sv =====
// Shared types for the Thumb instruction encoder.
// Holds the item descriptor passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tie_pkg;

  // Classified item: up to two immediate-load parts, then up to two direct halfwords
  typedef struct packed {
    logic        err;     // single error result
    logic [2:0]  n0;      // halfwords of load part 0 (0, 1, 2 or 4)
    logic [3:0]  reg0;
    logic [31:0] data0;
    logic [2:0]  n1;      // halfwords of load part 1 (0, 1, 2 or 4)
    logic [3:0]  reg1;
    logic [31:0] data1;
    logic [1:0]  nt;      // direct halfwords (0..2)
    logic [15:0] hw_a;
    logic [15:0] hw_b;
    logic [3:0]  total;   // halfwords in the whole item (1..8)
  } tie_desc_t;

  // Status of the descriptor queue
  typedef struct packed {
    logic full;
    logic valid;
  } tie_fifo_stat_t;

endpackage

`default_nettype wire

// ===== sv/tie_front.sv =====
// Front end of the Thumb instruction encoder: checks operands and classifies an item.
// Produces one descriptor per item; depends on tie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tie_front (
  input  wire logic [4:0]         in_operation,
  input  wire logic [3:0]         in_first_register,
  input  wire logic [3:0]         in_second_register,
  input  wire logic [3:0]         in_condition_code,
  input  wire logic               in_force_wide_form,
  input  wire logic signed [24:0] in_branch_distance,
  input  wire logic [63:0]        in_immediate_value,
  output tie_pkg::tie_desc_t      desc
);
  import tie_pkg::*;

  localparam logic [4:0] OP_MOVIMM32 = 5'd0;
  localparam logic [4:0] OP_MOVIMM64 = 5'd1;
  localparam logic [4:0] OP_B        = 5'd2;
  localparam logic [4:0] OP_BCOND    = 5'd3;
  localparam logic [4:0] OP_CMP      = 5'd4;
  localparam logic [4:0] OP_CALL     = 5'd5;
  localparam logic [4:0] OP_MOV      = 5'd6;
  localparam logic [4:0] OP_ADD3     = 5'd7;
  localparam logic [4:0] OP_MVN      = 5'd8;
  localparam logic [4:0] OP_AND      = 5'd9;
  localparam logic [4:0] OP_PUSH     = 5'd10;
  localparam logic [4:0] OP_POP      = 5'd11;
  localparam logic [4:0] OP_ADDSP    = 5'd12;
  localparam logic [4:0] OP_SUBSP    = 5'd13;
  localparam logic [4:0] OP_LDRSP    = 5'd14;
  localparam logic [4:0] OP_LDR      = 5'd15;
  localparam logic [4:0] OP_STR      = 5'd16;
  localparam logic [4:0] OP_PUSHALL  = 5'd17;
  localparam logic [4:0] OP_POPRET   = 5'd18;

  localparam logic [15:0] HW_BLX_R7   = 16'h47B8;
  localparam logic [15:0] HW_PUSHALL  = 16'hB5F0;
  localparam logic [15:0] HW_POPRET   = 16'hBDF0;
  localparam logic [3:0]  CALL_REG    = 4'd7;
  localparam logic [3:0]  COND_LIMIT  = 4'd14;

  // Halfword count of a 32-bit immediate load: MOVS, MOVW or MOVW+MOVT
  function automatic logic [2:0] load_count(input logic [31:0] data);
    if (data[31:8] == 24'd0) begin
      return 3'd1;
    end else if (data[31:16] == 16'd0) begin
      return 3'd2;
    end else begin
      return 3'd4;
    end
  endfunction

  logic [4:0]         op;
  logic [3:0]         ra;
  logic [3:0]         rb;
  logic [3:0]         rb_next;
  logic [31:0]        imm_hi;
  logic [31:0]        imm_lo;
  logic signed [24:0] d;
  logic [24:0]        dm2;
  logic               bad;
  tie_desc_t          work;

  assign op      = in_operation;
  assign ra      = in_first_register;
  assign rb      = in_second_register;
  assign rb_next = ra + 4'd1;
  assign imm_hi  = in_immediate_value[63:32];
  assign imm_lo  = in_immediate_value[31:0];
  assign d       = in_branch_distance;
  assign dm2     = d - 25'sd2;

  // Validate operands and build the descriptor
  always_comb begin
    work  = '0;
    bad   = 1'b0;
    unique case (op)
      OP_MOVIMM32: begin
        work.n0    = load_count(imm_lo);
        work.reg0  = ra;
        work.data0 = imm_lo;
        bad = (imm_hi != 32'd0) || (imm_lo[31:8] == 24'd0 && ra[3]);
      end
      OP_MOVIMM64: begin
        work.n0    = load_count(imm_hi);
        work.reg0  = ra;
        work.data0 = imm_hi;
        work.n1    = load_count(imm_lo);
        work.reg1  = rb_next;
        work.data1 = imm_lo;
        bad = (ra == 4'd15) || (imm_hi[31:8] == 24'd0 && ra[3]) ||
              (imm_lo[31:8] == 24'd0 && rb_next[3]);
      end
      OP_B: begin
        if (!in_force_wide_form && d >= -25'sd2044 && d < 25'sd2050) begin
          work.nt   = 2'd1;
          work.hw_a = {5'b11100, dm2[11:1]};
        end else begin
          work.nt   = 2'd2;
          work.hw_a = {5'b11110, d[24], d[21:12]};
          work.hw_b = {2'b10, ~(d[23] ^ d[24]), 1'b1, ~(d[22] ^ d[24]), d[11:1]};
        end
        bad = d[0];
      end
      OP_BCOND: begin
        bad = d[0] || (in_condition_code >= COND_LIMIT);
        if (!in_force_wide_form && d >= -25'sd254 && d < 25'sd258) begin
          work.nt   = 2'd1;
          work.hw_a = {4'b1101, in_condition_code, dm2[8:1]};
        end else if (d >= -25'sd1048576 && d < 25'sd1048574) begin
          work.nt   = 2'd2;
          work.hw_a = {5'b11110, d[20], in_condition_code, d[17:12]};
          work.hw_b = {2'b10, d[18], 1'b0, d[19], d[11:1]};
        end else begin
          bad = 1'b1;
        end
      end
      OP_CMP: begin
        work.nt   = 2'd1;
        work.hw_a = {5'b00101, ra[2:0], in_immediate_value[7:0]};
        bad = ra[3] || (in_immediate_value[63:8] != 56'd0);
      end
      OP_CALL: begin
        work.n0    = load_count(imm_lo);
        work.reg0  = CALL_REG;
        work.data0 = imm_lo;
        work.nt    = 2'd1;
        work.hw_a  = HW_BLX_R7;
        bad = (imm_hi != 32'd0);
      end
      OP_MOV: begin
        work.nt   = 2'd1;
        work.hw_a = {8'h46, ra[3], rb, ra[2:0]};
      end
      OP_ADD3: begin
        work.nt   = 2'd1;
        work.hw_a = {7'b0001110, in_immediate_value[2:0], rb[2:0], ra[2:0]};
        bad = ra[3] || rb[3] || (in_immediate_value[63:3] != 61'd0);
      end
      OP_MVN: begin
        work.nt   = 2'd1;
        work.hw_a = {10'b0100001111, rb[2:0], ra[2:0]};
        bad = ra[3] || rb[3];
      end
      OP_AND: begin
        work.nt   = 2'd1;
        work.hw_a = {10'b0100000000, rb[2:0], ra[2:0]};
        bad = ra[3] || rb[3];
      end
      OP_PUSH: begin
        work.nt   = 2'd1;
        work.hw_a = {8'hB4, 8'd1 << ra[2:0]};
        bad = ra[3];
      end
      OP_POP: begin
        work.nt   = 2'd1;
        work.hw_a = {8'hBC, 8'd1 << ra[2:0]};
        bad = ra[3];
      end
      OP_ADDSP: begin
        work.nt   = 2'd1;
        work.hw_a = {9'b101100000, in_immediate_value[8:2]};
        bad = (in_immediate_value[1:0] != 2'd0) || (in_immediate_value == 64'd0) ||
              (in_immediate_value[63:9] != 55'd0);
      end
      OP_SUBSP: begin
        work.nt   = 2'd1;
        work.hw_a = {9'b101100001, in_immediate_value[8:2]};
        bad = (in_immediate_value[1:0] != 2'd0) || (in_immediate_value == 64'd0) ||
              (in_immediate_value[63:9] != 55'd0);
      end
      OP_LDRSP: begin
        work.nt   = 2'd1;
        work.hw_a = {5'b10011, ra[2:0], in_immediate_value[9:2]};
        bad = ra[3] || (in_immediate_value[1:0] != 2'd0) ||
              (in_immediate_value > 64'd1020);
      end
      OP_LDR: begin
        work.nt   = 2'd1;
        work.hw_a = {5'b01101, in_immediate_value[6:2], rb[2:0], ra[2:0]};
        bad = ra[3] || rb[3] || (in_immediate_value[1:0] != 2'd0) ||
              (in_immediate_value[63:7] != 57'd0);
      end
      OP_STR: begin
        work.nt   = 2'd1;
        work.hw_a = {5'b01100, in_immediate_value[6:2], rb[2:0], ra[2:0]};
        bad = ra[3] || rb[3] || (in_immediate_value[1:0] != 2'd0) ||
              (in_immediate_value[63:7] != 57'd0);
      end
      OP_PUSHALL: begin
        work.nt   = 2'd1;
        work.hw_a = HW_PUSHALL;
      end
      OP_POPRET: begin
        work.nt   = 2'd1;
        work.hw_a = HW_POPRET;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // Replace with the single error result when any check failed
    if (bad) begin
      work      = '0;
      work.err  = 1'b1;
      work.nt   = 2'd1;
    end
    work.total = {1'b0, work.n0} + {1'b0, work.n1} + {2'b00, work.nt};
  end

  assign desc = work;

endmodule

`default_nettype wire

// ===== sv/tie_desc_fifo.sv =====
// Descriptor queue between the front and back ends of the Thumb encoder.
// Small register queue with a registered count; depends on tie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tie_desc_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire tie_pkg::tie_desc_t     push_desc,
  input  wire logic                   pop,
  output tie_pkg::tie_desc_t          head_desc,
  output tie_pkg::tie_fifo_stat_t     stat
);
  import tie_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tie_desc_t         entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign do_push = push && (count_r != FULL_CNT);
  assign do_pop  = pop && (count_r != '0);

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed descriptor
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head_desc  = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == FULL_CNT);
  assign stat.valid = (count_r != '0);

endmodule

`default_nettype wire

// ===== sv/tie_back.sv =====
// Back end of the Thumb encoder: expands the head descriptor into halfwords
// in the result register, one per cycle while it is free or popped; depends on tie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tie_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tie_pkg::tie_desc_t      head_desc,
  input  wire tie_pkg::tie_fifo_stat_t stat,
  output logic                         fifo_pop,
  input  wire logic                    out_pop,
  output logic                         out_empty,
  output logic [15:0]                  out_code_halfword,
  output logic                         out_last_halfword,
  output logic                         out_operand_error
);
  import tie_pkg::*;

  localparam logic [4:0] MOVS_TOP = 5'b00100;
  localparam logic [4:0] MOVW_TOP = 5'b11110;

  // Halfword j of an immediate load: MOVS, or MOVW pair then MOVT pair
  function automatic logic [15:0] load_hw(input logic [2:0] n, input logic [3:0] rg,
                                          input logic [31:0] data, input logic [1:0] j);
    logic [15:0] w;
    logic        top;
    w   = j[1] ? data[31:16] : data[15:0];
    top = j[1];
    if (n == 3'd1) begin
      return {MOVS_TOP, rg[2:0], data[7:0]};
    end else if (!j[0]) begin
      return {MOVW_TOP, w[11], 2'b10, top, 1'b1, 2'b00, w[15:12]};
    end else begin
      return {1'b0, w[10:8], rg, w[7:0]};
    end
  endfunction

  logic [2:0]  k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_hw_r;
  logic        out_last_r;
  logic        out_err_r;
  logic [3:0]  k4;
  logic [3:0]  end0;
  logic [3:0]  end1;
  logic [3:0]  off;
  logic [15:0] hw;
  logic        is_last;
  logic        take;
  logic        emit;

  assign k4      = {1'b0, k_r};
  assign end0    = {1'b0, head_desc.n0};
  assign end1    = end0 + {1'b0, head_desc.n1};
  assign is_last = (k4 == head_desc.total - 4'd1);
  assign take    = !out_valid_r || out_pop;
  assign emit    = take && stat.valid;
  assign fifo_pop = emit && is_last;

  // Select the current halfword by segment
  always_comb begin
    off = '0;
    priority if (k4 < end0) begin
      hw = load_hw(head_desc.n0, head_desc.reg0, head_desc.data0, k_r[1:0]);
    end else if (k4 < end1) begin
      off = k4 - end0;
      hw  = load_hw(head_desc.n1, head_desc.reg1, head_desc.data1, off[1:0]);
    end else begin
      off = k4 - end1;
      hw  = off[0] ? head_desc.hw_b : head_desc.hw_a;
    end
  end

  // Advance the halfword index and the result register
  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      k_nxt         = is_last ? 3'd0 : k_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_hw_r   <= hw;
      out_last_r <= is_last;
      out_err_r  <= head_desc.err;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_code_halfword = out_hw_r;
  assign out_last_halfword = out_last_r;
  assign out_operand_error = out_err_r;

endmodule

`default_nettype wire

// ===== sv/thumb_instruction_encoder_core.sv =====
// Thumb / Thumb-2 instruction encoder, top level.
// Input side is a queue: an item is taken at a clock edge with in_push high and
// in_full low. Each item names one instruction and its operands.
// Result side is a queue: while out_empty is low the oldest halfword is on
// out_code_halfword with out_last_halfword and out_operand_error; it is taken at
// an edge with out_pop high. An item gives its halfwords in program order, the
// final one marked last; a bad operand gives one result with error and last set.
// The first halfword of an item passes through the descriptor queue and then the
// back end's result register before it is on the result ports.
// Throughput: one halfword per cycle while the queue holds an item and the
// back end's single result register is free or popped; an item gives one
// halfword if narrow, two for wide branches, up to eight for a 64-bit load.
// A descriptor queue of QUEUE_DEPTH entries sits between the checking front end
// and the expanding back end; in_full rises when it is full.
// When out_pop stays low the result holds and the queue fills, then in_full rises.
// Reset (rst_n low, synchronous) empties the queue and the result register.
// Depends on tie_pkg, tie_front, tie_desc_fifo and tie_back.
`timescale 1ns / 1ps
`default_nettype none

module thumb_instruction_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [4:0]         in_operation,
  input  wire logic [3:0]         in_first_register,
  input  wire logic [3:0]         in_second_register,
  input  wire logic [3:0]         in_condition_code,
  input  wire logic               in_force_wide_form,
  input  wire logic signed [24:0] in_branch_distance,
  input  wire logic [63:0]        in_immediate_value,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [15:0]             out_code_halfword,
  output logic                    out_last_halfword,
  output logic                    out_operand_error
);
  import tie_pkg::*;

  tie_desc_t      front_desc;
  tie_desc_t      head_desc;
  tie_fifo_stat_t fifo_stat;
  logic           fifo_pop;
  logic           in_take;

  assign in_take = in_push && !fifo_stat.full;
  assign in_full = fifo_stat.full;

  // Check and classify the incoming item
  tie_front u_front (
    .in_operation       (in_operation),
    .in_first_register  (in_first_register),
    .in_second_register (in_second_register),
    .in_condition_code  (in_condition_code),
    .in_force_wide_form (in_force_wide_form),
    .in_branch_distance (in_branch_distance),
    .in_immediate_value (in_immediate_value),
    .desc               (front_desc)
  );

  // Hold classified items between the two ends
  tie_desc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_desc (front_desc),
    .pop       (fifo_pop),
    .head_desc (head_desc),
    .stat      (fifo_stat)
  );

  // Expand descriptors into halfwords
  tie_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_desc         (head_desc),
    .stat              (fifo_stat),
    .fifo_pop          (fifo_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_code_halfword (out_code_halfword),
    .out_last_halfword (out_last_halfword),
    .out_operand_error (out_operand_error)
  );

`ifndef SYNTH
  // An error result is a single zero halfword marked last
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_operand_error) |-> (out_last_halfword && out_code_halfword == 16'd0))
    else $error("error result not a single zero halfword");

  // A full queue always has a head for the back end
  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.full |-> fifo_stat.valid)
    else $error("queue full without a valid head");

  // Back end pops the queue only while it holds an item and the result slot is free
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> (fifo_stat.valid && (out_empty || out_pop)))
    else $error("queue popped without a head or a free result slot");

  // Leaving reset, both sides are empty
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (out_empty && !in_full))
    else $error("block not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for thumb_instruction_encoder_core: random and directed instructions are
// encoded by an in-bench predictor and every halfword is compared at the result queue.
// Depends on the encoder RTL (tie_pkg and the core with its submodules).
`timescale 1ns / 1ps

module tb_top;

  // Instruction codes as seen on in_operation
  typedef enum logic [4:0] {
    OP_MOVIMM32, OP_MOVIMM64, OP_B, OP_BCOND, OP_CMP, OP_CALL, OP_MOV, OP_ADD3,
    OP_MVN, OP_AND, OP_PUSH, OP_POP, OP_ADDSP, OP_SUBSP, OP_LDRSP, OP_LDR, OP_STR,
    OP_PUSHALL, OP_POPRET
  } instr_op_t;

  localparam int OP_CODE_TOP = 31;

  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;
  localparam logic [3:0] COND_NV = 4'd15;

  // Opcode templates
  localparam logic [15:0] HW_MOVS        = 16'h2000;
  localparam logic [15:0] HW_MOVW        = 16'hF240;
  localparam logic [15:0] HW_MOVT_BIT    = 16'h0080;
  localparam logic [15:0] HW_B_NARROW    = 16'hE000;
  localparam logic [15:0] HW_BCC_NARROW  = 16'hD000;
  localparam logic [15:0] HW_BW_HI       = 16'hF000;
  localparam logic [15:0] HW_B_WIDE_LO   = 16'h9000;
  localparam logic [15:0] HW_BCC_WIDE_LO = 16'h8000;
  localparam logic [15:0] HW_CMP         = 16'h2800;
  localparam logic [15:0] HW_BLX_R7      = 16'h47B8;
  localparam logic [15:0] HW_MOV         = 16'h4600;
  localparam logic [15:0] HW_ADD3        = 16'h1C00;
  localparam logic [15:0] HW_MVN         = 16'h43C0;
  localparam logic [15:0] HW_AND         = 16'h4000;
  localparam logic [15:0] HW_PUSH        = 16'hB400;
  localparam logic [15:0] HW_POP         = 16'hBC00;
  localparam logic [15:0] HW_ADDSP       = 16'hB000;
  localparam logic [15:0] HW_SUBSP       = 16'hB080;
  localparam logic [15:0] HW_LDRSP       = 16'h9800;
  localparam logic [15:0] HW_LDR         = 16'h6800;
  localparam logic [15:0] HW_STR         = 16'h6000;
  localparam logic [15:0] HW_PROLOGUE    = 16'hB5F0;
  localparam logic [15:0] HW_EPILOGUE    = 16'hBDF0;

  localparam int MAX_HALFWORDS = 8;
  localparam int RANDOM_ITEMS  = 400;

  typedef struct {
    logic [4:0]         op;
    logic [3:0]         ra;
    logic [3:0]         rb;
    logic [3:0]         cond;
    logic               wide;
    logic signed [24:0] distance;
    logic [63:0]        imm;
    bit                 drain;   // wait for every result before offering this item
  } instr_t;

  typedef struct {
    logic [15:0] hw;
    logic        last;
    logic        err;
  } halfword_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_push = 1'b0;
  logic               in_full;
  logic [4:0]         in_operation = '0;
  logic [3:0]         in_first_register = '0;
  logic [3:0]         in_second_register = '0;
  logic [3:0]         in_condition_code = '0;
  logic               in_force_wide_form = 1'b0;
  logic signed [24:0] in_branch_distance = '0;
  logic [63:0]        in_immediate_value = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [15:0]        out_code_halfword;
  logic               out_last_halfword;
  logic               out_operand_error;

  thumb_instruction_encoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_operation       (in_operation),
    .in_first_register  (in_first_register),
    .in_second_register (in_second_register),
    .in_condition_code  (in_condition_code),
    .in_force_wide_form (in_force_wide_form),
    .in_branch_distance (in_branch_distance),
    .in_immediate_value (in_immediate_value),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_code_halfword  (out_code_halfword),
    .out_last_halfword  (out_last_halfword),
    .out_operand_error  (out_operand_error)
  );

  always #5 clk = ~clk;

  instr_t    pending_instr_q[$];
  halfword_t expected_hw_q[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  halfwords_checked = 0;
  int  error_results = 0;
  int  full_stall_cycles = 0;
  bit  ops_seen[32];
  bit  rx_hold = 1'b0;

  // Encoder scratch: halfwords of the item being predicted
  logic [15:0] enc_buf[MAX_HALFWORDS];
  int          enc_len;
  bit          enc_bad;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void emit_hw(logic [15:0] v);
    if (enc_len < MAX_HALFWORDS) begin
      enc_buf[enc_len] = v;
      enc_len++;
    end else begin
      enc_bad = 1'b1;
    end
  endfunction

  // MOVW, or MOVT when top is set
  function automatic void emit_movw(logic [3:0] rd, bit top, logic [15:0] data);
    emit_hw(HW_MOVW | (top ? HW_MOVT_BIT : 16'h0) | {5'b0, data[11], 6'b0, data[15:12]});
    emit_hw({1'b0, data[10:8], rd, data[7:0]});
  endfunction

  // Shortest load of a 32-bit literal
  function automatic void emit_load32(logic [3:0] rd, logic [63:0] data);
    if (data > 64'hFFFF_FFFF) begin
      enc_bad = 1'b1;
    end else if (data < 256) begin
      if (rd >= 8) enc_bad = 1'b1;
      else emit_hw(HW_MOVS | {5'b0, rd[2:0], data[7:0]});
    end else if (data < 65536) begin
      emit_movw(rd, 1'b0, data[15:0]);
    end else begin
      emit_movw(rd, 1'b0, data[15:0]);
      emit_movw(rd, 1'b1, data[31:16]);
    end
  endfunction

  // Work out the halfwords one instruction must produce and queue them
  function automatic void encode_instruction(instr_t it);
    logic signed [31:0] d;
    logic [31:0]        u;
    logic [7:0]         mask;
    halfword_t          h;
    d = it.distance;
    u = d - 2;
    mask = 8'b1 << it.ra[2:0];
    enc_len = 0;
    enc_bad = 1'b0;
    case (it.op)
      OP_MOVIMM32: emit_load32(it.ra, it.imm);
      OP_MOVIMM64: begin
        if (it.ra >= 15) begin
          enc_bad = 1'b1;
        end else begin
          emit_load32(it.ra, {32'b0, it.imm[63:32]});
          emit_load32(it.ra + 4'd1, {32'b0, it.imm[31:0]});
        end
      end
      OP_B: begin
        if (it.distance[0]) begin
          enc_bad = 1'b1;
        end else if (!it.wide && d >= -2044 && d < 2050) begin
          emit_hw(HW_B_NARROW | {5'b0, u[11:1]});
        end else begin
          emit_hw(HW_BW_HI | {5'b0, d[24], d[21:12]});
          emit_hw(HW_B_WIDE_LO | {2'b0, ~(d[23] ^ d[24]), 1'b0, ~(d[22] ^ d[24]), d[11:1]});
        end
      end
      OP_BCOND: begin
        if (it.distance[0] || it.cond >= COND_AL) begin
          enc_bad = 1'b1;
        end else if (!it.wide && d >= -254 && d < 258) begin
          emit_hw(HW_BCC_NARROW | {4'b0, it.cond, u[8:1]});
        end else if (d >= -1048576 && d < 1048574) begin
          emit_hw(HW_BW_HI | {5'b0, d[20], it.cond, d[17:12]});
          emit_hw(HW_BCC_WIDE_LO | {2'b0, d[18], 1'b0, d[19], d[11:1]});
        end else begin
          enc_bad = 1'b1;
        end
      end
      OP_CMP: begin
        if (it.ra >= 8 || it.imm >= 256) enc_bad = 1'b1;
        else emit_hw(HW_CMP | {5'b0, it.ra[2:0], it.imm[7:0]});
      end
      OP_CALL: begin
        emit_load32(4'd7, it.imm);
        emit_hw(HW_BLX_R7);
      end
      OP_MOV: emit_hw(HW_MOV | {8'b0, it.ra[3], it.rb, it.ra[2:0]});
      OP_ADD3: begin
        if (it.ra >= 8 || it.rb >= 8 || it.imm >= 8) enc_bad = 1'b1;
        else emit_hw(HW_ADD3 | {7'b0, it.imm[2:0], it.rb[2:0], it.ra[2:0]});
      end
      OP_MVN, OP_AND: begin
        if (it.ra >= 8 || it.rb >= 8) enc_bad = 1'b1;
        else emit_hw((it.op == OP_MVN ? HW_MVN : HW_AND) | {10'b0, it.rb[2:0], it.ra[2:0]});
      end
      OP_PUSH, OP_POP: begin
        if (it.ra >= 8) enc_bad = 1'b1;
        else emit_hw((it.op == OP_PUSH ? HW_PUSH : HW_POP) | {8'b0, mask});
      end
      OP_ADDSP, OP_SUBSP: begin
        if (it.imm[1:0] != 2'b0 || it.imm == 0 || it.imm >= 512) enc_bad = 1'b1;
        else emit_hw((it.op == OP_ADDSP ? HW_ADDSP : HW_SUBSP) | {9'b0, it.imm[8:2]});
      end
      OP_LDRSP: begin
        if (it.ra >= 8 || it.imm[1:0] != 2'b0 || it.imm > 1020) enc_bad = 1'b1;
        else emit_hw(HW_LDRSP | {5'b0, it.ra[2:0], it.imm[9:2]});
      end
      OP_LDR, OP_STR: begin
        if (it.ra >= 8 || it.rb >= 8 || it.imm[1:0] != 2'b0 || it.imm >= 128)
          enc_bad = 1'b1;
        else
          emit_hw((it.op == OP_LDR ? HW_LDR : HW_STR) |
                  {5'b0, it.imm[6:2], it.rb[2:0], it.ra[2:0]});
      end
      OP_PUSHALL: emit_hw(HW_PROLOGUE);
      OP_POPRET: emit_hw(HW_EPILOGUE);
      default: enc_bad = 1'b1;
    endcase
    // A bad operand collapses the item to one error result
    if (enc_bad || enc_len == 0) begin
      h.hw = 16'h0;
      h.last = 1'b1;
      h.err = 1'b1;
      expected_hw_q.push_back(h);
    end else begin
      for (int k = 0; k < enc_len; k++) begin
        h.hw = enc_buf[k];
        h.last = (k == enc_len - 1);
        h.err = 1'b0;
        expected_hw_q.push_back(h);
      end
    end
  endfunction

  function automatic instr_t make_instr(logic [4:0] op, logic [3:0] ra, logic [3:0] rb,
                                        logic [3:0] cond, logic wide, int distance,
                                        logic [63:0] imm);
    instr_t it;
    it.op = op;
    it.ra = ra;
    it.rb = rb;
    it.cond = cond;
    it.wide = wide;
    it.distance = 25'(distance);
    it.imm = imm;
    it.drain = 1'b0;
    return it;
  endfunction

  // Literal of a random size class; the MOVS class only when the register allows it
  function automatic logic [31:0] rand_literal(bit narrow_ok);
    int unsigned pick = $urandom_range(narrow_ok ? 0 : 1, 2);
    case (pick)
      0: return $urandom_range(0, 255);
      1: return $urandom_range(256, 65535);
      default: return $urandom;
    endcase
  endfunction

  // Random instruction: mostly well-formed operands, the rest left as raw noise
  function automatic instr_t rand_instr();
    instr_t it;
    int     tmp;
    it.op = ($urandom_range(0, 99) < 5) ? 5'($urandom_range(OP_POPRET + 1, OP_CODE_TOP))
                                        : 5'($urandom_range(0, OP_POPRET));
    it.ra = 4'($urandom);
    it.rb = 4'($urandom);
    it.cond = 4'($urandom);
    it.wide = 1'($urandom);
    it.distance = 25'($urandom);
    it.imm = {$urandom, $urandom};
    it.drain = 1'b0;
    if ($urandom_range(0, 99) < 85) begin
      case (it.op)
        OP_MOVIMM32: it.imm = {32'b0, rand_literal(it.ra < 8)};
        OP_MOVIMM64: begin
          it.ra = 4'($urandom_range(0, 14));
          it.imm = {rand_literal(it.ra < 8), rand_literal(it.ra < 7)};
        end
        OP_CALL: it.imm = {32'b0, rand_literal(1'b1)};
        OP_B: begin
          if ($urandom_range(0, 1)) begin
            tmp = $urandom_range(0, 2046);
            it.distance = 25'(tmp * 2 - 2044);
          end
          it.distance[0] = 1'b0;
        end
        OP_BCOND: begin
          it.cond = 4'($urandom_range(COND_EQ, COND_LE));
          if ($urandom_range(0, 1)) begin
            tmp = $urandom_range(0, 255);
            it.distance = 25'(tmp * 2 - 254);
          end else begin
            tmp = $urandom_range(0, 1048574);
            it.distance = 25'(tmp * 2 - 1048576);
          end
        end
        OP_CMP: begin
          it.ra = 4'($urandom_range(0, 7));
          it.imm = $urandom_range(0, 255);
        end
        OP_ADD3: begin
          it.ra = 4'($urandom_range(0, 7));
          it.rb = 4'($urandom_range(0, 7));
          it.imm = $urandom_range(0, 7);
        end
        OP_MVN, OP_AND: begin
          it.ra = 4'($urandom_range(0, 7));
          it.rb = 4'($urandom_range(0, 7));
        end
        OP_PUSH, OP_POP: it.ra = 4'($urandom_range(0, 7));
        OP_ADDSP, OP_SUBSP: it.imm = 4 * $urandom_range(1, 127);
        OP_LDRSP: begin
          it.ra = 4'($urandom_range(0, 7));
          it.imm = 4 * $urandom_range(0, 255);
        end
        OP_LDR, OP_STR: begin
          it.ra = 4'($urandom_range(0, 7));
          it.rb = 4'($urandom_range(0, 7));
          it.imm = 4 * $urandom_range(0, 31);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // Sender: bursts of items with random gaps; an item marked drain waits for an empty queue
  instr_t in_flight;
  int     burst_left = 1;
  int     gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        encode_instruction(in_flight);
        ops_seen[in_flight.op] = 1'b1;
        items_sent++;
      end
      if (in_push && in_full) begin
        // hold the item until the block takes it
        full_stall_cycles++;
      end else if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pending_instr_q.size() != 0 &&
                   (!pending_instr_q[0].drain || expected_hw_q.size() == 0)) begin
        in_flight = pending_instr_q.pop_front();
        in_push <= 1'b1;
        in_operation <= in_flight.op;
        in_first_register <= in_flight.ra;
        in_second_register <= in_flight.rb;
        in_condition_code <= in_flight.cond;
        in_force_wide_form <= in_flight.wide;
        in_branch_distance <= in_flight.distance;
        in_immediate_value <= in_flight.imm;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: pop pattern changes mode at the end of each random-length phase
  int pop_mode = 0;
  int pop_phase = 0;
  int pop_tick = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      pop_tick++;
      if (pop_phase == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_phase = $urandom_range(20, 80);
      end else begin
        pop_phase--;
      end
      if (rx_hold) begin
        out_pop <= 1'b0;
      end else begin
        case (pop_mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          2: out_pop <= ($urandom_range(0, 9) < 3);
          default: out_pop <= (pop_tick % 8 < 5);
        endcase
      end
    end
  end

  // Monitor: compare each popped halfword with the oldest prediction
  halfword_t want;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (out_operand_error) error_results++;
      if (expected_hw_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_code_halfword, 16'h0);
      end else begin
        want = expected_hw_q.pop_front();
        halfwords_checked++;
        if (out_code_halfword !== want.hw)
          report_mismatch("code_halfword", out_code_halfword, want.hw);
        if (out_last_halfword !== want.last)
          report_mismatch("last_halfword", 16'(out_last_halfword), 16'(want.last));
        if (out_operand_error !== want.err)
          report_mismatch("operand_error", 16'(out_operand_error), 16'(want.err));
      end
    end
  end

  // Long receiver stall while the sender keeps offering, so the input side backs up
  initial begin
    while (items_sent < 120) @(negedge clk);
    rx_hold = 1'b1;
    repeat (400) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAIL thumb_instruction_encoder_core");
    $finish;
  end

  initial begin
    int     n_ops;
    instr_t it;
    n_ops = 0;

    // Directed: field extremes, every operation, and the corner cases
    pending_instr_q.push_back(make_instr(OP_MOVIMM32, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_MOVIMM32, 4'd7, 4'd15, COND_EQ, 1'b0, 0, 64'd255));
    pending_instr_q.push_back(make_instr(OP_MOVIMM32, 4'd8, 4'd0, COND_EQ, 1'b0, 0, 64'd5));
    pending_instr_q.push_back(make_instr(OP_MOVIMM32, 4'd15, 4'd0, COND_EQ, 1'b0, 0,
                                         64'hFFFF));
    pending_instr_q.push_back(make_instr(OP_MOVIMM32, 4'd3, 4'd0, COND_EQ, 1'b0, 0,
                                         64'hFFFF_FFFF));
    pending_instr_q.push_back(make_instr(OP_MOVIMM32, 4'd1, 4'd0, COND_EQ, 1'b0, 0,
                                         64'h1_0000_0000));
    pending_instr_q.push_back(make_instr(OP_MOVIMM64, 4'd14, 4'd0, COND_EQ, 1'b0, 0,
                                         64'hFFFF_FFFF_FFFF_FFFF));
    pending_instr_q.push_back(make_instr(OP_MOVIMM64, 4'd15, 4'd0, COND_EQ, 1'b0, 0, 64'd1));
    pending_instr_q.push_back(make_instr(OP_B, 4'd0, 4'd0, COND_EQ, 1'b0, -2044, 64'd0));
    pending_instr_q.push_back(make_instr(OP_B, 4'd0, 4'd0, COND_EQ, 1'b0, 2050, 64'd0));
    pending_instr_q.push_back(make_instr(OP_B, 4'd0, 4'd0, COND_EQ, 1'b0, -16777216, 64'd0));
    pending_instr_q.push_back(make_instr(OP_B, 4'd0, 4'd0, COND_EQ, 1'b1, 16777214, 64'd0));
    pending_instr_q.push_back(make_instr(OP_B, 4'd0, 4'd0, COND_EQ, 1'b0, 3, 64'd0));
    pending_instr_q.push_back(make_instr(OP_BCOND, 4'd0, 4'd0, COND_EQ, 1'b0, -254, 64'd0));
    pending_instr_q.push_back(make_instr(OP_BCOND, 4'd0, 4'd0, COND_LE, 1'b0, 256, 64'd0));
    pending_instr_q.push_back(make_instr(OP_BCOND, 4'd0, 4'd0, COND_AL, 1'b0, 8, 64'd0));
    pending_instr_q.push_back(make_instr(OP_BCOND, 4'd0, 4'd0, COND_NV, 1'b1, 8, 64'd0));
    pending_instr_q.push_back(make_instr(OP_BCOND, 4'd0, 4'd0, COND_LE, 1'b0, -1048576, 64'd0));
    pending_instr_q.push_back(make_instr(OP_BCOND, 4'd0, 4'd0, COND_EQ, 1'b0, 1048574, 64'd0));
    pending_instr_q.push_back(make_instr(OP_CMP, 4'd7, 4'd0, COND_EQ, 1'b0, 0, 64'd255));
    pending_instr_q.push_back(make_instr(OP_CALL, 4'd0, 4'd0, COND_EQ, 1'b0, 0,
                                         64'h1234_5678));
    pending_instr_q.push_back(make_instr(OP_MOV, 4'd15, 4'd15, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_ADD3, 4'd7, 4'd7, COND_EQ, 1'b0, 0, 64'd7));
    pending_instr_q.push_back(make_instr(OP_MVN, 4'd7, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_AND, 4'd8, 4'd1, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_PUSH, 4'd7, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_POP, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_ADDSP, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd508));
    pending_instr_q.push_back(make_instr(OP_SUBSP, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_LDRSP, 4'd7, 4'd9, COND_EQ, 1'b0, 0, 64'd1020));
    pending_instr_q.push_back(make_instr(OP_LDR, 4'd7, 4'd7, COND_EQ, 1'b0, 0, 64'd124));
    pending_instr_q.push_back(make_instr(OP_STR, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd128));
    pending_instr_q.push_back(make_instr(OP_PUSHALL, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(OP_POPRET, 4'd0, 4'd0, COND_EQ, 1'b0, 0, 64'd0));
    pending_instr_q.push_back(make_instr(5'(OP_CODE_TOP), 4'd0, 4'd0, COND_EQ, 1'b0, 0,
                                         64'd0));

    // Random part; two items wait for the result queue to drain first
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      it = rand_instr();
      it.drain = (i == 0 || i == 260);
      pending_instr_q.push_back(it);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Let everything be offered, taken and checked, then watch for stray results
    while (pending_instr_q.size() != 0 || in_push) @(posedge clk);
    while (expected_hw_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    foreach (ops_seen[k]) if (ops_seen[k]) n_ops++;
    $display("Sent %0d items over %0d of 32 operation codes; checked %0d halfwords",
             items_sent, n_ops, halfwords_checked);
    $display("Error results: %0d, cycles with input held off by in_full: %0d",
             error_results, full_stall_cycles);
    if (mismatches == 0) begin
      $display("PASS thumb_instruction_encoder_core");
    end else begin
      $display("FAIL thumb_instruction_encoder_core");
    end
    $finish;
  end

endmodule
